// ===== rtl/rpf_pkg.sv =====
// Shared types and constants for the rotated packed-pixel framebuffer.
package rpf_pkg;

  localparam int CRD_W   = 9;
  localparam int LVL_W   = 2;
  localparam int LOC_W   = 18;
  localparam int MAX_DIM = 256;

  localparam logic [CRD_W-1:0] DIM_RESET = 9'd256;

  localparam logic [7:0] MONO_MSB  = 8'h80;
  localparam logic [7:0] GRAY_MSB  = 8'hC0;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam logic [LVL_W-1:0] LVL_WHITE = 2'd3;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;
  localparam logic [1:0] REG_GRAY     = 2'd3;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_RECT = 2'd2,
    CMD_FILL = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PIX_RD,
    BK_PIX_WR,
    BK_FILL,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [CRD_W-1:0] width;
    logic [CRD_W-1:0] height;
    logic [1:0]       rotation;
    logic             gray;
  } cfg_t;

  typedef struct packed {
    cmd_e_t           cmd;
    logic [CRD_W-1:0] x0;
    logic [CRD_W-1:0] y0;
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] y1;
    logic [LVL_W-1:0] level;
    logic             inb;
  } job_t;

endpackage

// ===== rtl/rpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rpf_front.sv =====
// Front end: bounds check and rectangle clamping of incoming requests.
module rpf_front (
  input  rpf_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [rpf_pkg::CRD_W-1:0]     in_pos_x,
  input  logic [rpf_pkg::CRD_W-1:0]     in_pos_y,
  input  logic [rpf_pkg::CRD_W-1:0]     in_end_x,
  input  logic [rpf_pkg::CRD_W-1:0]     in_end_y,
  input  logic [rpf_pkg::LVL_W-1:0]     in_level,
  input  logic                          q_full,
  output logic                          push,
  output rpf_pkg::job_t                 push_job
);

  logic                      sideways;
  logic [rpf_pkg::CRD_W-1:0] eff_w;
  logic [rpf_pkg::CRD_W-1:0] eff_h;
  logic                      inb;
  rpf_pkg::cmd_e_t           cmd;

  assign sideways = (cfg.rotation == rpf_pkg::ROT_90) || (cfg.rotation == rpf_pkg::ROT_270);
  assign eff_w    = sideways ? cfg.height : cfg.width;
  assign eff_h    = sideways ? cfg.width : cfg.height;
  assign inb      = (in_pos_x < eff_w) && (in_pos_y < eff_h);
  assign cmd      = rpf_pkg::cmd_e_t'(in_cmd);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_job.cmd   = cmd;
    push_job.level = in_level;
    push_job.x0    = in_pos_x;
    push_job.y0    = in_pos_y;
    push_job.x1    = in_end_x;
    push_job.y1    = in_end_y;
    push_job.inb   = inb;
    unique case (cmd)
      rpf_pkg::CMD_RECT: begin
        push_job.x0 = (in_pos_x > eff_w) ? eff_w : in_pos_x;
        push_job.y0 = (in_pos_y > eff_h) ? eff_h : in_pos_y;
        push_job.x1 = (in_end_x > eff_w) ? eff_w : in_end_x;
        push_job.y1 = (in_end_y > eff_h) ? eff_h : in_end_y;
      end
      rpf_pkg::CMD_FILL: begin
        push_job.inb = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/rpf_queue.sv =====
// Two-entry request queue between front and back ends.
module rpf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output rpf_pkg::job_t q_job
);

  rpf_pkg::job_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = ent_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/rpf_back.sv =====
// Back end: pixel read-modify-write, rectangle walk, memory fill and result register.
module rpf_back #(
  parameter int MEM_BYTES = 16384
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpf_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  rpf_pkg::job_t             q_job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rpf_pkg::LVL_W-1:0] out_read_level,
  output logic                      out_in_bounds
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  rpf_pkg::bk_state_t state_r, state_nxt;
  rpf_pkg::job_t      job_r, job_nxt;
  logic [rpf_pkg::CRD_W-1:0] cx_r, cx_nxt;
  logic [rpf_pkg::CRD_W-1:0] cy_r, cy_nxt;
  logic [AW-1:0]             fcnt_r, fcnt_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic                      hit_r, hit_nxt;
  logic [2:0]                sel_r, sel_nxt;
  logic [rpf_pkg::LVL_W-1:0] rd_r, rd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [rpf_pkg::LVL_W-1:0] out_level_r, out_level_nxt;
  logic                      out_inb_r, out_inb_nxt;

  logic [rpf_pkg::CRD_W-1:0] px, py;
  logic [9:0]                rb_sum;
  logic [7:0]                rb;
  logic [16:0]               prod;
  logic [rpf_pkg::LOC_W-1:0] a_full;
  logic                      hit;
  logic [2:0]                gshift;
  logic [7:0]                mask, bits, merged, rsh, fill_pat;
  logic [rpf_pkg::LVL_W-1:0] rd_level;
  logic [rpf_pkg::CRD_W:0]   cx_inc, cy_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  rpf_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Logical to physical coordinates, then byte address.
  always_comb begin
    unique case (cfg.rotation)
      rpf_pkg::ROT_90: begin
        px = cfg.width - rpf_pkg::CRD_W'(1) - cy_r;
        py = cx_r;
      end
      rpf_pkg::ROT_180: begin
        px = cfg.width - rpf_pkg::CRD_W'(1) - cx_r;
        py = cfg.height - rpf_pkg::CRD_W'(1) - cy_r;
      end
      rpf_pkg::ROT_270: begin
        px = cy_r;
        py = cfg.height - rpf_pkg::CRD_W'(1) - cx_r;
      end
      default: begin
        px = cx_r;
        py = cy_r;
      end
    endcase
    if (cfg.gray) begin
      rb_sum = {1'b0, cfg.width} + 10'd3;
      rb     = rb_sum[9:2];
      prod   = py * rb;
      a_full = rpf_pkg::LOC_W'(prod) + rpf_pkg::LOC_W'(px[rpf_pkg::CRD_W-1:2]);
    end else begin
      rb_sum = {1'b0, cfg.width} + 10'd7;
      rb     = {1'b0, rb_sum[9:3]};
      prod   = py * rb;
      a_full = rpf_pkg::LOC_W'(prod) + rpf_pkg::LOC_W'(px[rpf_pkg::CRD_W-1:3]);
    end
    hit = (32'(a_full) < MEM_BYTES);
  end

  // Byte merge and pixel extraction.
  always_comb begin
    gshift = {sel_r[1:0], 1'b0};
    if (cfg.gray) begin
      mask     = rpf_pkg::GRAY_MSB >> gshift;
      bits     = {job_r.level, 6'b0} >> gshift;
      rsh      = ram_rdata << gshift;
      rd_level = rsh[7:6];
    end else begin
      mask     = rpf_pkg::MONO_MSB >> sel_r;
      bits     = (job_r.level == rpf_pkg::LVL_WHITE) ? mask : 8'h00;
      rsh      = ram_rdata << sel_r;
      rd_level = rsh[7] ? rpf_pkg::LVL_WHITE : '0;
    end
    merged = (ram_rdata & ~mask) | bits;
    if (cfg.gray) begin
      fill_pat = {4{job_r.level}};
    end else begin
      fill_pat = (job_r.level == rpf_pkg::LVL_WHITE) ? rpf_pkg::BYTE_ONES : 8'h00;
    end
  end

  assign cx_inc = {1'b0, cx_r} + 1'b1;
  assign cy_inc = {1'b0, cy_r} + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    fcnt_nxt      = fcnt_r;
    addr_nxt      = addr_r;
    hit_nxt       = hit_r;
    sel_nxt       = sel_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_inb_nxt   = out_inb_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = merged;
    ram_raddr     = AW'(a_full);
    unique case (state_r)
      rpf_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          job_nxt  = q_job;
          cx_nxt   = q_job.x0;
          cy_nxt   = q_job.y0;
          fcnt_nxt = '0;
          rd_nxt   = rpf_pkg::LVL_WHITE;
          unique case (q_job.cmd)
            rpf_pkg::CMD_SET, rpf_pkg::CMD_GET: begin
              state_nxt = q_job.inb ? rpf_pkg::BK_PIX_RD : rpf_pkg::BK_DONE;
            end
            rpf_pkg::CMD_RECT: begin
              state_nxt = ((q_job.x0 < q_job.x1) && (q_job.y0 < q_job.y1)) ?
                          rpf_pkg::BK_PIX_RD : rpf_pkg::BK_DONE;
            end
            default: begin
              state_nxt = rpf_pkg::BK_FILL;
            end
          endcase
        end
      end
      rpf_pkg::BK_PIX_RD: begin
        hit_nxt   = hit;
        addr_nxt  = AW'(a_full);
        sel_nxt   = px[2:0];
        state_nxt = rpf_pkg::BK_PIX_WR;
      end
      rpf_pkg::BK_PIX_WR: begin
        priority case (job_r.cmd)
          rpf_pkg::CMD_GET: begin
            rd_nxt    = hit_r ? rd_level : rpf_pkg::LVL_WHITE;
            state_nxt = rpf_pkg::BK_DONE;
          end
          rpf_pkg::CMD_SET: begin
            ram_we    = hit_r;
            state_nxt = rpf_pkg::BK_DONE;
          end
          default: begin
            ram_we    = hit_r;
            state_nxt = rpf_pkg::BK_PIX_RD;
            if (cx_inc < {1'b0, job_r.x1}) begin
              cx_nxt = cx_inc[rpf_pkg::CRD_W-1:0];
            end else begin
              cx_nxt = job_r.x0;
              if (cy_inc < {1'b0, job_r.y1}) begin
                cy_nxt = cy_inc[rpf_pkg::CRD_W-1:0];
              end else begin
                state_nxt = rpf_pkg::BK_DONE;
              end
            end
          end
        endcase
      end
      rpf_pkg::BK_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fcnt_r;
        ram_wdata = fill_pat;
        fcnt_nxt  = fcnt_r + 1'b1;
        if (fcnt_r == LAST_ADDR) begin
          state_nxt = rpf_pkg::BK_DONE;
        end
      end
      rpf_pkg::BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = rd_r;
          out_inb_nxt   = job_r.inb;
          state_nxt     = rpf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rpf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    fcnt_r      <= fcnt_nxt;
    addr_r      <= addr_nxt;
    hit_r       <= hit_nxt;
    sel_r       <= sel_nxt;
    rd_r        <= rd_nxt;
    out_level_r <= out_level_nxt;
    out_inb_r   <= out_inb_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_level = out_level_r;
  assign out_in_bounds  = out_inb_r;

endmodule

// ===== rtl/rotated_packed_framebuffer.sv =====
// Rotated packed-pixel framebuffer: request queue, pixel engine and configuration registers.
//
// Requests arrive on in_* (valid/stall) and carry a command, a logical point, a rectangle
// end point and a level. Each request returns exactly one result on out_* (valid/stall):
// the level read back by a get, otherwise 3, and whether the start point was in bounds (always 1 for a fill).
// The front end checks and clamps against the rotated size and queues up to two requests;
// the back end executes one request at a time against a byte memory with one read port
// and one write port.
// An in-bounds set or get passes through BK_PIX_RD (memory read), BK_PIX_WR (write, or
// read-back for a get) and BK_DONE; one out of bounds or an empty rectangle goes straight
// to BK_DONE; a rectangle runs BK_PIX_RD and BK_PIX_WR once per covered pixel; and a
// fill writes every byte of the memory, one byte per cycle. The back end takes no new
// request until the current one has handed its result to out_*.
// cfg_we writes register cfg_index (0 width, 1 height, 2 rotation, 3 gray mode); width
// and height are clamped to 1..MAX_DIM. Write configuration only while no request is open.
// Reset empties the queue and the result register and sets 256 x 256, no rotation, mono.
// Memory contents are not cleared: a fill or a set must write a byte before it is read.
// While out_stall is high the result is held, and the queue keeps taking requests until
// it is full, then in_stall rises.
module rotated_packed_framebuffer #(
  parameter int MEM_BYTES = 16384
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [rpf_pkg::CRD_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [rpf_pkg::CRD_W-1:0] in_pos_x,
  input  logic [rpf_pkg::CRD_W-1:0] in_pos_y,
  input  logic [rpf_pkg::CRD_W-1:0] in_end_x,
  input  logic [rpf_pkg::CRD_W-1:0] in_end_y,
  input  logic [rpf_pkg::LVL_W-1:0] in_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rpf_pkg::LVL_W-1:0] out_read_level,
  output logic                      out_in_bounds
);

  rpf_pkg::cfg_t cfg_r, cfg_nxt;
  logic [rpf_pkg::CRD_W-1:0] dim_clamped;

  logic          q_full, push, pop, q_valid;
  rpf_pkg::job_t push_job, q_job;

  always_comb begin
    if (cfg_data == '0) begin
      dim_clamped = rpf_pkg::CRD_W'(1);
    end else if (32'(cfg_data) > rpf_pkg::MAX_DIM) begin
      dim_clamped = rpf_pkg::CRD_W'(rpf_pkg::MAX_DIM);
    end else begin
      dim_clamped = cfg_data;
    end
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rpf_pkg::REG_WIDTH:    cfg_nxt.width    = dim_clamped;
        rpf_pkg::REG_HEIGHT:   cfg_nxt.height   = dim_clamped;
        rpf_pkg::REG_ROTATION: cfg_nxt.rotation = cfg_data[1:0];
        rpf_pkg::REG_GRAY:     cfg_nxt.gray     = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= rpf_pkg::DIM_RESET;
      cfg_r.height   <= rpf_pkg::DIM_RESET;
      cfg_r.rotation <= rpf_pkg::ROT_NONE;
      cfg_r.gray     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rpf_front u_front (
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_pos_x (in_pos_x),
    .in_pos_y (in_pos_y),
    .in_end_x (in_end_x),
    .in_end_y (in_end_y),
    .in_level (in_level),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  rpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  rpf_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_level (out_read_level),
    .out_in_bounds  (out_in_bounds)
  );

endmodule
